FILE: hw/rtl/ffsa_pkg.sv
// shared types and constants for the first-fit segment allocator
// no dependencies; used by ffsa_ctrl, ffsa_datapath and the top level

package ffsa_pkg;

    localparam int SIZE_W  = 11;
    localparam int OWNER_W = 16;
    localparam int START_W = 10;

    // memory_size after reset
    localparam logic [SIZE_W-1:0] RESET_MEM_SIZE = 11'd1024;

    // word index of the configuration register
    localparam logic [0:0] REG_MEMORY_SIZE = 1'b0;

    typedef enum logic [1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_FREE     = 2'd1,
        MODE_COALESCE = 2'd2,
        MODE_REINIT   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NOFIT = 3'd1,
        ST_FULL  = 3'd2,
        ST_NOID  = 3'd3,
        ST_ZERO  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_SPLIT,
        S_GRANT,
        S_RELEASE,
        S_PACK_END,
        S_POST
    } state_t;

    typedef struct packed {
        logic               used;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
    } entry_t;

    typedef struct packed {
        logic    init;
        logic    start;
        logic    reinit;
        logic    scan;
        logic    shift_setup;
        logic    shift;
        logic    split;
        logic    grant;
        logic    release_seg;
        logic    pack_end;
        logic    set_res;
        status_t res_code;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  req_zero;
        logic  hit;
        logic  last_miss;
        logic  split;
        logic  full;
        logic  shift_done;
    } dp_stat_t;

endpackage

FILE: hw/rtl/ffsa_ctrl.sv
// controller state machine of the segment allocator
// depends on ffsa_pkg; drives ffsa_datapath through dp_cmd_t

module ffsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ffsa_pkg::dp_stat_t stat,
    output ffsa_pkg::dp_cmd_t  cmd
);

    ffsa_pkg::state_t state_reg;
    ffsa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffsa_pkg::S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        case (state_reg)
            ffsa_pkg::S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ffsa_pkg::S_IDLE;
            end
            ffsa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ffsa_pkg::S_DISPATCH;
                end
            end
            ffsa_pkg::S_DISPATCH:
            begin
                case (stat.mode)
                    ffsa_pkg::MODE_ALLOC:
                    begin
                        if (stat.req_zero)
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ffsa_pkg::ST_ZERO;
                            state_next   = ffsa_pkg::S_POST;
                        end
                        else
                        begin
                            state_next = ffsa_pkg::S_SCAN;
                        end
                    end
                    ffsa_pkg::MODE_FREE,
                    ffsa_pkg::MODE_COALESCE:
                    begin
                        state_next = ffsa_pkg::S_SCAN;
                    end
                    ffsa_pkg::MODE_REINIT:
                    begin
                        cmd.reinit   = 1'b1;
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ffsa_pkg::ST_OK;
                        state_next   = ffsa_pkg::S_POST;
                    end
                    default:
                    begin
                        state_next = ffsa_pkg::S_IDLE;
                    end
                endcase
            end
            ffsa_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    if (stat.mode == ffsa_pkg::MODE_FREE)
                    begin
                        state_next = ffsa_pkg::S_RELEASE;
                    end
                    else if (!stat.split)
                    begin
                        state_next = ffsa_pkg::S_GRANT;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ffsa_pkg::ST_FULL;
                        state_next   = ffsa_pkg::S_POST;
                    end
                    else
                    begin
                        cmd.shift_setup = 1'b1;
                        state_next      = ffsa_pkg::S_SHIFT;
                    end
                end
                else if (stat.last_miss)
                begin
                    if (stat.mode == ffsa_pkg::MODE_COALESCE)
                    begin
                        state_next = ffsa_pkg::S_PACK_END;
                    end
                    else
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = (stat.mode == ffsa_pkg::MODE_ALLOC) ?
                                       ffsa_pkg::ST_NOFIT : ffsa_pkg::ST_NOID;
                        state_next   = ffsa_pkg::S_POST;
                    end
                end
            end
            ffsa_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = ffsa_pkg::S_SPLIT;
                end
            end
            ffsa_pkg::S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ffsa_pkg::S_GRANT;
            end
            ffsa_pkg::S_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = ffsa_pkg::S_POST;
            end
            ffsa_pkg::S_RELEASE:
            begin
                cmd.release_seg = 1'b1;
                cmd.set_res     = 1'b1;
                cmd.res_code    = ffsa_pkg::ST_OK;
                state_next      = ffsa_pkg::S_POST;
            end
            ffsa_pkg::S_PACK_END:
            begin
                cmd.pack_end = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = ffsa_pkg::ST_OK;
                state_next   = ffsa_pkg::S_POST;
            end
            ffsa_pkg::S_POST:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ffsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.init, cmd.reinit, cmd.shift_setup, cmd.split, cmd.grant,
                  cmd.release_seg, cmd.pack_end}))
        else $error("more than one table write command at once");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new beat taken while an operation is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

endmodule

FILE: hw/rtl/ffsa_datapath.sv
// segment table memory, scan pipeline, split/merge logic and result registers
// depends on ffsa_pkg; steered by ffsa_ctrl

module ffsa_datapath
#(
    parameter int MEM_UNITS    = 1024,
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ffsa_pkg::dp_cmd_t                cmd,
    output ffsa_pkg::dp_stat_t               stat,
    input  logic [ffsa_pkg::SIZE_W-1:0]      memory_size,
    input  logic [1:0]                       mode,
    input  logic [ffsa_pkg::SIZE_W-1:0]      request_size,
    input  logic [ffsa_pkg::OWNER_W-1:0]     release_id,
    output logic [2:0]                       status,
    output logic [ffsa_pkg::OWNER_W-1:0]     granted_id,
    output logic [ffsa_pkg::START_W-1:0]     granted_start
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [16:0]                   UNITS_W  = 17'(MEM_UNITS);
    localparam logic [ffsa_pkg::SIZE_W-1:0]   UNITS_SZ = ffsa_pkg::SIZE_W'(MEM_UNITS);
    localparam logic [CW-1:0]                 MAX_CNT  = CW'(MAX_SEGMENTS);

    ffsa_pkg::entry_t mem [MAX_SEGMENTS];
    ffsa_pkg::entry_t rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IW-1:0] ev_idx_reg, ev_idx_next;
    logic          ev_vld_reg, ev_vld_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [ffsa_pkg::SIZE_W-1:0] hit_size_reg, hit_size_next;
    logic [ffsa_pkg::SIZE_W-1:0] base_reg, base_next;
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          pend_vld_reg, pend_vld_next;
    ffsa_pkg::entry_t pend_reg, pend_next;
    logic [ffsa_pkg::OWNER_W-1:0] next_id_reg, next_id_next;

    ffsa_pkg::mode_t              mode_reg;
    logic [ffsa_pkg::SIZE_W-1:0]  req_reg;
    logic [ffsa_pkg::OWNER_W-1:0] rid_reg;

    ffsa_pkg::status_t            res_status_reg;
    logic [ffsa_pkg::OWNER_W-1:0] res_id_reg;
    logic [ffsa_pkg::START_W-1:0] res_start_reg;
    ffsa_pkg::status_t            out_status_reg;
    logic [ffsa_pkg::OWNER_W-1:0] out_id_reg;
    logic [ffsa_pkg::START_W-1:0] out_start_reg;

    logic             we_c;
    logic [IW-1:0]    waddr_c;
    ffsa_pkg::entry_t wdata_c;
    logic             rd_en_c;
    logic [IW-1:0]    rd_addr_c;
    logic             match_c;
    logic             last_c;

    // zero becomes one, anything above the space becomes the space
    function automatic logic [ffsa_pkg::SIZE_W-1:0] clamp_size(
        input logic [ffsa_pkg::SIZE_W-1:0] val);
        logic [ffsa_pkg::SIZE_W-1:0] n;
        n = (val == '0) ? ffsa_pkg::SIZE_W'(1) : val;
        if ({6'd0, n} > UNITS_W)
        begin
            n = UNITS_SZ;
        end
        return n;
    endfunction

    // segment table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we_c)
        begin
            mem[waddr_c] <= wdata_c;
        end
        if (rd_en_c)
        begin
            rdata_reg <= mem[rd_addr_c];
        end
    end

    always_comb
    begin
        case (mode_reg)
            ffsa_pkg::MODE_ALLOC: match_c = !rdata_reg.used && (rdata_reg.size >= req_reg);
            ffsa_pkg::MODE_FREE:  match_c = rdata_reg.used && (rdata_reg.owner == rid_reg);
            default:              match_c = 1'b0;
        endcase
    end

    assign last_c = ev_vld_reg && (CW'(ev_idx_reg) == (count_reg - CW'(1)));

    assign stat.mode       = mode_reg;
    assign stat.req_zero   = (req_reg == '0);
    assign stat.hit        = ev_vld_reg && match_c;
    assign stat.last_miss  = last_c && !match_c;
    assign stat.split      = (rdata_reg.size != req_reg);
    assign stat.full       = (count_reg == MAX_CNT);
    assign stat.shift_done = !ev_vld_reg && !(rd_ptr_reg > CW'(hit_idx_reg));

    always_comb
    begin
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        ev_idx_next   = ev_idx_reg;
        ev_vld_next   = 1'b0;
        hit_idx_next  = hit_idx_reg;
        hit_size_next = hit_size_reg;
        base_next     = base_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        next_id_next  = next_id_reg;
        we_c          = 1'b0;
        waddr_c       = '0;
        wdata_c       = '0;
        rd_en_c       = 1'b0;
        rd_addr_c     = rd_ptr_reg[IW-1:0];

        if (cmd.start)
        begin
            rd_ptr_next   = '0;
            base_next     = '0;
            wr_ptr_next   = '0;
            pend_vld_next = 1'b0;
        end

        if (cmd.scan)
        begin
            if (rd_ptr_reg < count_reg)
            begin
                rd_en_c     = 1'b1;
                rd_ptr_next = rd_ptr_reg + CW'(1);
                ev_vld_next = 1'b1;
                ev_idx_next = rd_ptr_reg[IW-1:0];
            end
            if (ev_vld_reg)
            begin
                if (mode_reg == ffsa_pkg::MODE_COALESCE)
                begin
                    if (!pend_vld_reg)
                    begin
                        pend_next     = rdata_reg;
                        pend_vld_next = 1'b1;
                    end
                    else if (!pend_reg.used && !rdata_reg.used)
                    begin
                        pend_next.size = pend_reg.size + rdata_reg.size;
                    end
                    else
                    begin
                        we_c        = 1'b1;
                        waddr_c     = wr_ptr_reg;
                        wdata_c     = pend_reg;
                        wr_ptr_next = wr_ptr_reg + IW'(1);
                        pend_next   = rdata_reg;
                    end
                end
                else if (match_c)
                begin
                    hit_idx_next  = ev_idx_reg;
                    hit_size_next = rdata_reg.size;
                end
                else
                begin
                    base_next = base_reg + rdata_reg.size;
                end
            end
        end

        if (cmd.shift_setup)
        begin
            rd_ptr_next = count_reg - CW'(1);
            ev_vld_next = 1'b0;
        end

        // move entries up by one, highest first
        if (cmd.shift)
        begin
            if (rd_ptr_reg > CW'(hit_idx_reg))
            begin
                rd_en_c     = 1'b1;
                rd_ptr_next = rd_ptr_reg - CW'(1);
                ev_vld_next = 1'b1;
                ev_idx_next = rd_ptr_reg[IW-1:0];
            end
            if (ev_vld_reg)
            begin
                we_c    = 1'b1;
                waddr_c = ev_idx_reg + IW'(1);
                wdata_c = rdata_reg;
            end
        end

        if (cmd.split)
        begin
            we_c       = 1'b1;
            waddr_c    = hit_idx_reg + IW'(1);
            wdata_c    = '{used: 1'b0, owner: '0, size: hit_size_reg - req_reg};
            count_next = count_reg + CW'(1);
        end

        if (cmd.grant)
        begin
            we_c         = 1'b1;
            waddr_c      = hit_idx_reg;
            wdata_c      = '{used: 1'b1, owner: next_id_reg, size: req_reg};
            next_id_next = (next_id_reg == '1) ? ffsa_pkg::OWNER_W'(1)
                                               : next_id_reg + ffsa_pkg::OWNER_W'(1);
        end

        if (cmd.release_seg)
        begin
            we_c    = 1'b1;
            waddr_c = hit_idx_reg;
            wdata_c = '{used: 1'b0, owner: '0, size: hit_size_reg};
        end

        if (cmd.pack_end)
        begin
            we_c       = 1'b1;
            waddr_c    = wr_ptr_reg;
            wdata_c    = pend_reg;
            count_next = CW'(wr_ptr_reg) + CW'(1);
        end

        if (cmd.init)
        begin
            we_c       = 1'b1;
            waddr_c    = '0;
            wdata_c    = '{used: 1'b0, owner: '0, size: clamp_size(ffsa_pkg::RESET_MEM_SIZE)};
            count_next = CW'(1);
        end

        if (cmd.reinit)
        begin
            we_c       = 1'b1;
            waddr_c    = '0;
            wdata_c    = '{used: 1'b0, owner: '0, size: clamp_size(memory_size)};
            count_next = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CW'(1);
            next_id_reg  <= ffsa_pkg::OWNER_W'(1);
            rd_ptr_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            rd_ptr_reg   <= rd_ptr_next;
            ev_vld_reg   <= ev_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg   <= ev_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_size_reg <= hit_size_next;
        base_reg     <= base_next;
        wr_ptr_reg   <= wr_ptr_next;
        pend_reg     <= pend_next;
        if (cmd.start)
        begin
            mode_reg <= ffsa_pkg::mode_t'(mode);
            req_reg  <= request_size;
            rid_reg  <= release_id;
        end
        if (cmd.grant)
        begin
            res_status_reg <= ffsa_pkg::ST_OK;
            res_id_reg     <= next_id_reg;
            res_start_reg  <= base_reg[ffsa_pkg::START_W-1:0];
        end
        else if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            res_id_reg     <= '0;
            res_start_reg  <= '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_start_reg  <= res_start_reg;
        end
    end

    assign status        = out_status_reg;
    assign granted_id    = out_id_reg;
    assign granted_start = out_start_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= MAX_CNT))
        else $error("segment count out of range");

    a_split_has_rest: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |-> ((hit_size_reg > req_reg) && (count_reg < MAX_CNT)))
        else $error("split without a remainder or with a full table");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (next_id_reg != '0))
        else $error("owner id zero handed out");

endmodule

FILE: hw/rtl/first_fit_segment_allocator_core.sv
// first-fit segment allocator: one operation at a time, result held in an output register.
// allocate answers a zero size at once, else scans for the first free segment that fits and,
// when that segment is larger, shifts the later entries up and splits it; free and coalesce
// scan the table, reinitialize writes a single free segment; the next beat is taken in the
// cycle after the result is posted; a held result delays posting.
// reset clears control state, then the controller writes the initial free segment; depends
// on ffsa_pkg, ffsa_ctrl and ffsa_datapath

module first_fit_segment_allocator_core
#(
    parameter int MEM_UNITS    = 1024,
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [10:0] request_size,
    input  logic [15:0] release_id,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] granted_id,
    output logic [9:0]  granted_start
);

    logic [ffsa_pkg::SIZE_W-1:0] memory_size_reg;
    logic                        cfg_wr;
    ffsa_pkg::dp_cmd_t           cmd;
    ffsa_pkg::dp_stat_t          stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == ffsa_pkg::REG_MEMORY_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= ffsa_pkg::RESET_MEM_SIZE;
        end
        else if (cfg_wr)
        begin
            memory_size_reg <= pwdata[ffsa_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2:2] == ffsa_pkg::REG_MEMORY_SIZE) ? 32'(memory_size_reg) : '0;

    ffsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffsa_datapath
    #(
        .MEM_UNITS    (MEM_UNITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .memory_size   (memory_size_reg),
        .mode          (mode),
        .request_size  (request_size),
        .release_id    (release_id),
        .status        (status),
        .granted_id    (granted_id),
        .granted_start (granted_start)
    );

endmodule

FILE: tb/ffsa_checker.sv
// result checker for the first-fit segment allocator: keeps its own copy of the
// segment table, predicts each request beat's result and compares the result beats
// depends on ffsa_pkg; instantiated by testbench beside the block

module ffsa_checker
#(
    parameter int MEM_UNITS    = 1024,
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [10:0] request_size,
    input  logic [15:0] release_id,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] granted_id,
    input  logic [9:0]  granted_start,

    output int          failures,
    output int          outstanding
);
    import ffsa_pkg::*;

    localparam logic [2:0] SIZE_REG_ADDR = {REG_MEMORY_SIZE, 2'b00};

    typedef struct packed {
        status_t            code;
        logic [OWNER_W-1:0] owner;
        logic [START_W-1:0] start;
    } grant_t;

    // shadow of the segment table
    logic [SIZE_W-1:0]  seg_len   [MAX_SEGMENTS];
    logic [OWNER_W-1:0] seg_owner [MAX_SEGMENTS];
    logic               seg_busy  [MAX_SEGMENTS];
    int                 seg_total;
    logic [OWNER_W-1:0] id_counter;
    logic [SIZE_W-1:0]  space_cfg;

    grant_t awaited_grants[$];
    grant_t due;
    grant_t seen;
    int     fault_count;

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", what);
    endtask

    task automatic rebuild_space();
        logic [SIZE_W-1:0] units;
        units = space_cfg;
        if (units == 0)
            units = 1;
        if (units > MEM_UNITS)
            units = SIZE_W'(MEM_UNITS);
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            seg_len[i]   = '0;
            seg_owner[i] = '0;
            seg_busy[i]  = 1'b0;
        end
        seg_len[0] = units;
        seg_total  = 1;
    endtask

    task automatic grant_first_fit(input logic [SIZE_W-1:0] want, output grant_t r);
        int hit;
        int base;
        hit = -1;
        base = 0;
        r = '{ST_OK, '0, '0};
        for (int i = 0; i < seg_total && hit < 0; i++)
        begin
            if (!seg_busy[i] && seg_len[i] >= want)
                hit = i;
            else
                base += seg_len[i];
        end
        if (want == 0)
            r.code = ST_ZERO;
        else if (hit < 0)
            r.code = ST_NOFIT;
        else if (seg_len[hit] > want && seg_total >= MAX_SEGMENTS)
            r.code = ST_FULL;   // split needs a free slot, later segments are not tried
        else
        begin
            if (seg_len[hit] > want)
            begin
                for (int k = seg_total; k > hit + 1; k--)
                begin
                    seg_len[k]   = seg_len[k-1];
                    seg_owner[k] = seg_owner[k-1];
                    seg_busy[k]  = seg_busy[k-1];
                end
                seg_len[hit+1]   = seg_len[hit] - want;
                seg_owner[hit+1] = '0;
                seg_busy[hit+1]  = 1'b0;
                seg_len[hit]     = want;
                seg_total++;
            end
            seg_busy[hit]  = 1'b1;
            seg_owner[hit] = id_counter;
            r.owner = id_counter;
            r.start = START_W'(base);
            id_counter = (id_counter == '1) ? 16'd1 : id_counter + 16'd1;
        end
    endtask

    task automatic release_owner(input logic [OWNER_W-1:0] rid, output grant_t r);
        int hit;
        hit = -1;
        r = '{ST_NOID, '0, '0};
        for (int i = 0; i < seg_total && hit < 0; i++)
            if (seg_busy[i] && seg_owner[i] == rid)
                hit = i;
        if (hit >= 0)
        begin
            seg_busy[hit]  = 1'b0;
            seg_owner[hit] = '0;
            r.code = ST_OK;
        end
    endtask

    task automatic merge_free_runs();
        int i;
        i = 0;
        while (i + 1 < seg_total)
        begin
            if (!seg_busy[i] && !seg_busy[i+1])
            begin
                seg_len[i] = seg_len[i] + seg_len[i+1];
                for (int k = i + 1; k + 1 < seg_total; k++)
                begin
                    seg_len[k]   = seg_len[k+1];
                    seg_owner[k] = seg_owner[k+1];
                    seg_busy[k]  = seg_busy[k+1];
                end
                seg_total--;
                seg_len[seg_total]   = '0;
                seg_owner[seg_total] = '0;
                seg_busy[seg_total]  = 1'b0;
            end
            else
                i++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_cfg  = RESET_MEM_SIZE;
            id_counter = 16'd1;
            rebuild_space();
            awaited_grants.delete();
            outstanding <= 0;
            failures    <= fault_count;
        end
        else
        begin
            if (psel && penable && pready && paddr == SIZE_REG_ADDR)
            begin
                if (pwrite)
                    space_cfg = pwdata[SIZE_W-1:0];
                else if (prdata[SIZE_W-1:0] !== space_cfg)
                    note_fault($sformatf("size register read back %0d, expected %0d",
                                         prdata[SIZE_W-1:0], space_cfg));
            end

            if (out_valid && out_ready)
            begin
                seen = '{status_t'(status), granted_id, granted_start};
                if (awaited_grants.size() == 0)
                    note_fault($sformatf("unexpected result: status %0d id %0d start %0d",
                                         status, granted_id, granted_start));
                else
                begin
                    due = awaited_grants.pop_front();
                    if (seen !== due)
                        note_fault($sformatf(
                            "mismatch: expected status %0d id %0d start %0d, got %0d %0d %0d",
                            due.code, due.owner, due.start,
                            status, granted_id, granted_start));
                end
            end

            if (in_valid && in_ready)
            begin
                case (mode_t'(mode))
                    MODE_ALLOC:
                        grant_first_fit(request_size, due);
                    MODE_FREE:
                        release_owner(release_id, due);
                    MODE_COALESCE:
                    begin
                        merge_free_runs();
                        due = '{ST_OK, '0, '0};
                    end
                    default:
                    begin
                        rebuild_space();   // id counter survives a rebuild
                        due = '{ST_OK, '0, '0};
                    end
                endcase
                awaited_grants.push_back(due);
            end

            outstanding <= awaited_grants.size();
            failures    <= fault_count;
        end
    end

    initial
        fault_count = 0;

endmodule

FILE: tb/testbench.sv
// top of the allocator testbench: clock, reset, request and register stimulus,
// output back-pressure and the final verdict
// depends on ffsa_pkg, ffsa_checker and first_fit_segment_allocator_core

module testbench;
    import ffsa_pkg::*;

    localparam int MEM_UNITS    = 1024;
    localparam int MAX_SEGMENTS = 32;
    localparam int RANDOM_OPS   = 500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [2:0] SIZE_REG_ADDR = {REG_MEMORY_SIZE, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [10:0] request_size;
    logic [15:0] release_id;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] granted_id;
    logic [9:0]  granted_start;

    int failures;
    int outstanding;

    int cycles = 0;
    int ops_sent = 0;
    int directed_ops;
    int burst_left = 0;
    int hold_asks = 0;
    int holds_done = 0;
    int size_writes = 0;
    int space_units = MEM_UNITS;
    int op_tally[4] = '{0, 0, 0, 0};
    int status_tally[8] = '{0, 0, 0, 0, 0, 0, 0, 0};
    logic [15:0] live_ids[$];

    first_fit_segment_allocator_core
    #(
        .MEM_UNITS    (MEM_UNITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    )
    dut (.*);

    ffsa_checker
    #(
        .MEM_UNITS    (MEM_UNITS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    )
    result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: changing stall styles, plus long hold-offs on request
    initial
    begin
        int style;
        int style_left;
        style = 0;
        style_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // granted ids feed the free requests
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            status_tally[status]++;
            if (status == ST_OK && granted_id != 0)
                live_ids.push_back(granted_id);
        end
    end

    task automatic offer(input mode_t op, input logic [10:0] units, input logic [15:0] owner);
        int gap;
        in_valid     <= 1'b1;
        mode         <= op;
        request_size <= units;
        release_id   <= owner;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ops_sent++;
        op_tally[op]++;
        if (op == MODE_REINIT)
            live_ids.delete();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // write then read back the size register
    task automatic write_space(input logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_REG_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        size_writes++;
        space_units = (value == 0) ? 1 : ((value > MEM_UNITS) ? MEM_UNITS : value);
    endtask

    function automatic logic [10:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return 11'($urandom);
        else if (roll < 30)
            return 11'($urandom_range(1, space_units));
        else
            return 11'($urandom_range(1, (space_units + 7) / 8));
    endfunction

    function automatic logic [15:0] pick_owner();
        int idx;
        logic [15:0] owner;
        if (live_ids.size() > 0 && $urandom_range(0, 4) != 0)
        begin
            idx = $urandom_range(0, live_ids.size() - 1);
            owner = live_ids[idx];
            live_ids.delete(idx);
        end
        else
            owner = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        return owner;
    endfunction

    task automatic workload_round();
        int roll;
        repeat (70)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                offer(MODE_ALLOC, pick_size(), 16'($urandom));
            else if (roll < 87)
                offer(MODE_FREE, 11'($urandom), pick_owner());
            else if (roll < 97)
                offer(MODE_COALESCE, 11'($urandom), 16'($urandom));
            else
                offer(MODE_REINIT, 11'($urandom), 16'($urandom));
        end
    endtask

    // many small grants run the table out of entries
    task automatic fill_round();
        repeat (36) offer(MODE_ALLOC, 11'($urandom_range(1, 8)), 16'($urandom));
        repeat (12) offer(MODE_FREE, 11'($urandom), pick_owner());
        repeat (6) offer(MODE_ALLOC, 11'($urandom_range(1, 8)), 16'($urandom));
        offer(MODE_COALESCE, 11'($urandom), 16'($urandom));
        repeat (8) offer(MODE_ALLOC, pick_size(), 16'($urandom));
    endtask

    task automatic noise_round();
        repeat (40) offer(mode_t'($urandom_range(0, 3)), 11'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int round;
        logic [10:0] space_plan[8];
        logic [10:0] setting;
        space_plan = '{11'd0, 11'd1024, 11'd2047, 11'd40, 11'd1, 11'd1023, 11'd2, 11'd600};
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        mode         <= MODE_ALLOC;
        request_size <= '0;
        release_id   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset space of 1024 units, ids start at 1
        offer(MODE_ALLOC, 11'd0, 16'd0);
        offer(MODE_ALLOC, 11'h7FF, 16'd0);
        offer(MODE_ALLOC, 11'd1025, 16'd0);
        offer(MODE_FREE, 11'd0, 16'd0);
        offer(MODE_ALLOC, 11'd1024, 16'd0);
        offer(MODE_ALLOC, 11'd1, 16'd0);
        offer(MODE_FREE, 11'd0, 16'd1);
        offer(MODE_FREE, 11'd0, 16'd1);
        offer(MODE_ALLOC, 11'd1, 16'd0);
        offer(MODE_ALLOC, 11'd1023, 16'd0);
        offer(MODE_FREE, 11'd0, 16'd2);
        offer(MODE_FREE, 11'd0, 16'd3);
        offer(MODE_ALLOC, 11'd1024, 16'd0);
        offer(MODE_COALESCE, 11'd0, 16'd0);
        offer(MODE_ALLOC, 11'd1024, 16'd0);
        offer(MODE_FREE, 11'd0, 16'hFFFF);
        offer(MODE_REINIT, 11'h7FF, 16'hFFFF);
        offer(MODE_ALLOC, 11'd512, 16'd0);
        offer(MODE_ALLOC, 11'd256, 16'd0);
        offer(MODE_ALLOC, 11'd256, 16'd0);
        offer(MODE_FREE, 11'd0, 16'd6);
        offer(MODE_ALLOC, 11'd100, 16'd0);
        offer(MODE_COALESCE, 11'd0, 16'd0);
        offer(MODE_FREE, 11'd0, 16'd7);
        offer(MODE_COALESCE, 11'd0, 16'd0);
        directed_ops = ops_sent;
        wait_drained();

        round = 0;
        while (ops_sent - directed_ops < RANDOM_OPS)
        begin
            if (round < 8)
                setting = space_plan[round];
            else
                setting = 11'($urandom_range(1, MEM_UNITS));
            write_space(setting);
            offer(MODE_REINIT, 11'($urandom), 16'($urandom));
            if (round % 4 == 1)
                hold_asks++;
            case (round % 3)
                0: workload_round();
                1: fill_round();
                default: noise_round();
            endcase
            wait_drained();
            round++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests (%0d alloc, %0d free, %0d coalesce, %0d reinit), %0d size writes",
                 ops_sent, op_tally[MODE_ALLOC], op_tally[MODE_FREE],
                 op_tally[MODE_COALESCE], op_tally[MODE_REINIT], size_writes);
        $display("outcomes: %0d ok, %0d no fit, %0d table full, %0d unknown id, %0d zero size",
                 status_tally[ST_OK], status_tally[ST_NOFIT], status_tally[ST_FULL],
                 status_tally[ST_NOID], status_tally[ST_ZERO]);
        if (failures == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
